### rtl/jsv_pkg.sv
// shared types and constants of the json syntax validator
package jsv_pkg;

  // lexer states: structure, strings, keys, words, numbers
  typedef enum logic [4:0] {
    S_VALUE, S_ARR_FIRST, S_OBJ_FIRST, S_OBJ_KEY, S_COLON, S_AFTER,
    S_STR, S_STR_ESC, S_STR_HEX, S_KEY, S_KEY_ESC, S_KEY_HEX,
    S_LIT0, S_LIT1, S_LIT2, S_LIT3, S_LIT4, S_LIT5, S_LIT6, S_LIT7, S_LIT8,
    S_LIT9,
    N_MINUS, N_ZERO, N_INT, N_DOT, N_FRAC, N_E, N_ESIGN, N_EXP
  } lex_state_t;

  // document status codes
  localparam logic [1:0] DOC_VALID  = 2'd0;
  localparam logic [1:0] DOC_SYNTAX = 2'd1;
  localparam logic [1:0] DOC_DEPTH  = 2'd2;

  // nesting kinds
  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  // request from the lexer to the nesting stack
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stk_op_t;

  // view of the nesting stack for the lexer
  typedef struct packed {
    logic depth_zero;
    logic depth_one;
    logic full;
    logic top_kind;
  } stk_stat_t;

endpackage

### rtl/json_syntax_validator_core.sv
// JSON syntax validator: checks one document, one byte per clock cycle while no untaken
// result holds in_ready low. Each accepted item is one byte of the document; the byte with
// in_last_byte set ends it and produces one result item on out_doc_status (0 valid, 1 syntax
// error, 2 nesting deeper than MAX_DEPTH); other bytes produce none, and the next document
// may start as soon as in_ready allows. Every byte, including the last, is taken with no
// stalls of its own: the kind of the innermost open level sits in a register and the stack
// memory (one write and one registered read port, MAX_DEPTH entries) always holds the entry
// below it prefetched, so a pop never waits. After the first error the rest of the document
// is skipped and the first error is reported. No clearing pass is needed after reset.
module json_syntax_validator_core
  import jsv_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_doc_status
);

  lex_state_t st_r, st_nxt;
  logic [2:0] hex_r, hex_nxt;
  logic [1:0] err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;

  lex_state_t lex_st;
  logic [2:0] lex_hex;
  logic [1:0] lex_flag;
  stk_op_t    lex_op, stk_op;
  stk_stat_t  stk_stat;

  logic accept, active, doc_end;
  logic done, zero_after;

  // output register parts the channels
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign active   = accept && (err_r == DOC_VALID);
  assign doc_end  = accept && in_last_byte;
  assign stk_op   = active ? lex_op : '0;

  jsv_lexer u_lexer (
    .st        (st_r),
    .hex_left  (hex_r),
    .data_byte (in_data_byte),
    .stat      (stk_stat),
    .st_nxt    (lex_st),
    .hex_nxt   (lex_hex),
    .flag      (lex_flag),
    .op        (lex_op)
  );

  jsv_nest_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (doc_end),
    .op    (stk_op),
    .stat  (stk_stat)
  );

  // document complete after this byte
  always_comb begin
    done = (lex_st == S_AFTER) || (lex_st == N_ZERO) || (lex_st == N_INT) ||
           (lex_st == N_FRAC) || (lex_st == N_EXP);
    if (lex_op.pop) zero_after = stk_stat.depth_one;
    else if (lex_op.push) zero_after = 1'b0;
    else zero_after = stk_stat.depth_zero;
  end

  // lexer state, held error and result
  always_comb begin
    st_nxt        = st_r;
    hex_nxt       = hex_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    if (doc_end) begin
      st_nxt        = S_VALUE;
      hex_nxt       = 3'd0;
      err_nxt       = DOC_VALID;
      out_valid_nxt = 1'b1;
      if (err_r != DOC_VALID) status_nxt = err_r;
      else if (lex_flag != DOC_VALID) status_nxt = lex_flag;
      else if (done && zero_after) status_nxt = DOC_VALID;
      else status_nxt = DOC_SYNTAX;
    end else if (active) begin
      st_nxt  = lex_st;
      hex_nxt = lex_hex;
      err_nxt = lex_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_VALUE;
      hex_r       <= 3'd0;
      err_r       <= DOC_VALID;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      hex_r       <= hex_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_doc_status = status_r;

endmodule

### rtl/jsv_nest_stack.sv
// nesting kind stack: top level in a register, the rest in a registered-read memory
module jsv_nest_stack
  import jsv_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clear,
  input  stk_op_t   op,
  output stk_stat_t stat
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          kind_mem [MAX_DEPTH];
  logic [DW-1:0] depth_r, depth_nxt;
  logic          top_r, top_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          rd_data_r;
  logic          byp_r, byp_nxt;
  logic          byp_data_r;
  logic          below;

  // entry under the top: prefetched last cycle, or the value just written
  assign below = byp_r ? byp_data_r : rd_data_r;

  // push spills the old top into memory, pop refills it from below, clear empties the stack
  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(depth_r - DW'(1));
    if (clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      wr_en     = (depth_r != '0);
      top_nxt   = op.kind;
      depth_nxt = depth_r + DW'(1);
    end else if (op.pop) begin
      top_nxt   = below;
      depth_nxt = depth_r - DW'(1);
    end
  end

  // prefetch the entry that will sit under the new top
  always_comb begin
    rd_addr = '0;
    if ({1'b0, depth_nxt} >= (DW + 1)'(2)) begin
      rd_addr = AW'(depth_nxt - DW'(2));
    end
    byp_nxt = wr_en && (wr_addr == rd_addr);
  end

  // memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_mem[wr_addr] <= top_r;
    end
    rd_data_r <= kind_mem[rd_addr];
  end

  // depth and bypass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      byp_r   <= byp_nxt;
    end
  end

  // top kind and bypass data
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  assign stat.depth_zero = (depth_r == '0);
  assign stat.depth_one  = (depth_r == DW'(1));
  assign stat.full       = ({1'b0, depth_r} >= (DW + 1)'(MAX_DEPTH));
  assign stat.top_kind   = top_r;

endmodule

### rtl/jsv_lexer.sv
// next-state decode of the lexer for one byte
module jsv_lexer
  import jsv_pkg::*;
(
  input  lex_state_t st,
  input  logic [2:0] hex_left,
  input  logic [7:0] data_byte,
  input  stk_stat_t  stat,
  output lex_state_t st_nxt,
  output logic [2:0] hex_nxt,
  output logic [1:0] flag,
  output stk_op_t    op
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // expected letter in each word state: true, false, null back to back
  function automatic logic [7:0] word_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "r";
      4'd1:    ch = "u";
      4'd2:    ch = "e";
      4'd3:    ch = "a";
      4'd4:    ch = "l";
      4'd5:    ch = "s";
      4'd6:    ch = "e";
      4'd7:    ch = "u";
      4'd8:    ch = "l";
      4'd9:    ch = "l";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic word_last(input logic [3:0] idx);
    return (idx == 4'd2) || (idx == 4'd6) || (idx == 4'd9);
  endfunction

  logic       is_ws, is_digit, is_hex, is_expo, is_escape;
  logic [3:0] lit_idx;
  logic       is_num;
  logic       num_end;
  lex_state_t s_eff;
  logic [2:0] hex_dec;
  // value start decode
  lex_state_t vs_st;
  logic       vs_open, vs_kind, vs_bad;

  assign is_ws    = (data_byte == 8'h20) || (data_byte == 8'h09) ||
                    (data_byte == 8'h0A) || (data_byte == 8'h0D);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_hex   = is_digit || (data_byte >= "a" && data_byte <= "f") ||
                    (data_byte >= "A" && data_byte <= "F");
  assign is_expo  = (data_byte == "e") || (data_byte == "E");
  assign is_escape = (data_byte == CH_QUOTE) || (data_byte == CH_BSLASH) ||
                     (data_byte == CH_SLASH) || (data_byte == "b") ||
                     (data_byte == "f") || (data_byte == "n") ||
                     (data_byte == "r") || (data_byte == "t");
  assign is_num   = (st >= N_MINUS);
  assign hex_dec  = (hex_left != 3'd0) ? hex_left - 3'd1 : hex_left;

  // first byte of a value
  always_comb begin
    vs_st   = st;
    vs_open = 1'b0;
    vs_kind = KIND_ARRAY;
    vs_bad  = 1'b0;
    if (data_byte == CH_QUOTE) begin
      vs_st = S_STR;
    end else if (data_byte == CH_MINUS) begin
      vs_st = N_MINUS;
    end else if (data_byte == CH_ZERO) begin
      vs_st = N_ZERO;
    end else if (is_digit) begin
      vs_st = N_INT;
    end else if (data_byte == CH_LBRACK) begin
      vs_open = 1'b1;
      vs_kind = KIND_ARRAY;
    end else if (data_byte == CH_LBRACE) begin
      vs_open = 1'b1;
      vs_kind = KIND_OBJECT;
    end else if (data_byte == "t") begin
      vs_st = S_LIT0;
    end else if (data_byte == "f") begin
      vs_st = S_LIT3;
    end else if (data_byte == "n") begin
      vs_st = S_LIT7;
    end else begin
      vs_bad = 1'b1;
    end
  end

  // number states; a byte that ends a number is handled again after the value
  always_comb begin
    num_end = 1'b0;
    case (st)
      N_ZERO, N_INT: begin
        if (!(is_digit && st == N_INT) && data_byte != CH_DOT && !is_expo) begin
          num_end = 1'b1;
        end
      end
      N_FRAC: num_end = !is_digit && !is_expo;
      N_EXP:  num_end = !is_digit;
      default: num_end = 1'b0;
    endcase
    s_eff   = num_end ? S_AFTER : st;
    lit_idx = 4'(5'(s_eff) - 5'(S_LIT0));
  end

  always_comb begin
    st_nxt  = st;
    hex_nxt = hex_left;
    flag    = DOC_VALID;
    op      = '0;
    if (num_end) begin
      st_nxt = S_AFTER;
    end
    if (is_num && !num_end) begin
      // inside a number
      case (st)
        N_MINUS: begin
          if (data_byte == CH_ZERO) st_nxt = N_ZERO;
          else if (is_digit) st_nxt = N_INT;
          else flag = DOC_SYNTAX;
        end
        N_ZERO, N_INT: begin
          if (data_byte == CH_DOT) st_nxt = N_DOT;
          else if (is_expo) st_nxt = N_E;
        end
        N_DOT: begin
          if (is_digit) st_nxt = N_FRAC;
          else flag = DOC_SYNTAX;
        end
        N_FRAC: begin
          if (is_expo) st_nxt = N_E;
        end
        N_E: begin
          if (data_byte == CH_PLUS || data_byte == CH_MINUS) st_nxt = N_ESIGN;
          else if (is_digit) st_nxt = N_EXP;
          else flag = DOC_SYNTAX;
        end
        N_ESIGN: begin
          if (is_digit) st_nxt = N_EXP;
          else flag = DOC_SYNTAX;
        end
        default: ;
      endcase
    end else begin
      case (s_eff)
        // words
        S_LIT0, S_LIT1, S_LIT2, S_LIT3, S_LIT4, S_LIT5, S_LIT6, S_LIT7, S_LIT8,
        S_LIT9: begin
          if (data_byte != word_char(lit_idx)) flag = DOC_SYNTAX;
          else if (word_last(lit_idx)) st_nxt = S_AFTER;
          else st_nxt = lex_state_t'(5'(s_eff) + 5'd1);
        end
        // string and key bodies
        S_STR, S_KEY: begin
          if (data_byte == CH_QUOTE) st_nxt = (s_eff == S_KEY) ? S_COLON : S_AFTER;
          else if (data_byte == CH_BSLASH) st_nxt = (s_eff == S_KEY) ? S_KEY_ESC : S_STR_ESC;
          else if (data_byte < 8'h20) flag = DOC_SYNTAX;
        end
        S_STR_ESC, S_KEY_ESC: begin
          if (is_escape) begin
            st_nxt = (s_eff == S_KEY_ESC) ? S_KEY : S_STR;
          end else if (data_byte == "u") begin
            hex_nxt = 3'd4;
            st_nxt  = (s_eff == S_KEY_ESC) ? S_KEY_HEX : S_STR_HEX;
          end else begin
            flag = DOC_SYNTAX;
          end
        end
        S_STR_HEX, S_KEY_HEX: begin
          if (!is_hex) begin
            flag = DOC_SYNTAX;
          end else begin
            hex_nxt = hex_dec;
            if (hex_dec == 3'd0) st_nxt = (s_eff == S_KEY_HEX) ? S_KEY : S_STR;
          end
        end
        // structure
        S_VALUE, S_ARR_FIRST: begin
          if (is_ws) begin
            st_nxt = s_eff;
          end else if (s_eff == S_ARR_FIRST && data_byte == CH_RBRACK) begin
            if (stat.depth_zero || stat.top_kind != KIND_ARRAY) flag = DOC_SYNTAX;
            else begin
              op.pop = 1'b1;
              st_nxt = S_AFTER;
            end
          end else if (vs_bad) begin
            flag = DOC_SYNTAX;
          end else if (vs_open) begin
            if (stat.full) flag = DOC_DEPTH;
            else begin
              op.push = 1'b1;
              op.kind = vs_kind;
              st_nxt  = (vs_kind == KIND_OBJECT) ? S_OBJ_FIRST : S_ARR_FIRST;
            end
          end else begin
            st_nxt = vs_st;
          end
        end
        S_OBJ_FIRST: begin
          if (is_ws) begin
            st_nxt = s_eff;
          end else if (data_byte == CH_RBRACE) begin
            if (stat.depth_zero || stat.top_kind != KIND_OBJECT) flag = DOC_SYNTAX;
            else begin
              op.pop = 1'b1;
              st_nxt = S_AFTER;
            end
          end else if (data_byte == CH_QUOTE) begin
            st_nxt = S_KEY;
          end else begin
            flag = DOC_SYNTAX;
          end
        end
        S_OBJ_KEY: begin
          if (data_byte == CH_QUOTE) st_nxt = S_KEY;
          else if (!is_ws) flag = DOC_SYNTAX;
        end
        S_COLON: begin
          if (data_byte == CH_COLON) st_nxt = S_VALUE;
          else if (!is_ws) flag = DOC_SYNTAX;
        end
        S_AFTER: begin
          if (is_ws) begin
            st_nxt = S_AFTER;
          end else if (data_byte == CH_COMMA) begin
            if (stat.depth_zero) flag = DOC_SYNTAX;
            else st_nxt = (stat.top_kind == KIND_OBJECT) ? S_OBJ_KEY : S_VALUE;
          end else if (data_byte == CH_RBRACK || data_byte == CH_RBRACE) begin
            if (stat.depth_zero ||
                stat.top_kind != ((data_byte == CH_RBRACE) ? KIND_OBJECT : KIND_ARRAY)) begin
              flag = DOC_SYNTAX;
            end else begin
              op.pop = 1'b1;
              st_nxt = S_AFTER;
            end
          end else begin
            flag = DOC_SYNTAX;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
